// File: src/mwfb_pkg.sv
// Shared types, constants and the CRC-16/Modbus byte update for the frame builder.
package mwfb_pkg;

    // Largest number of data words in one frame; larger counts are clamped
    localparam int MAX_WORDS = 16;
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);

    // CRC-16/Modbus
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ID  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_CODE = 1'b1;

    // Byte positions within the request of a frame's first item
    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] POS_SLAVE   = 4'd0;
    localparam logic [POS_W-1:0] POS_FUNC    = 4'd1;
    localparam logic [POS_W-1:0] POS_ADDR_HI = 4'd2;
    localparam logic [POS_W-1:0] POS_ADDR_LO = 4'd3;
    localparam logic [POS_W-1:0] POS_CNT_HI  = 4'd4;
    localparam logic [POS_W-1:0] POS_CNT_LO  = 4'd5;
    localparam logic [POS_W-1:0] POS_BYTES   = 4'd6;
    localparam logic [POS_W-1:0] POS_DATA_HI = 4'd7;
    localparam logic [POS_W-1:0] POS_DATA_LO = 4'd8;
    localparam logic [POS_W-1:0] POS_CRC_LO  = 4'd9;
    localparam logic [POS_W-1:0] POS_CRC_HI  = 4'd10;

    typedef struct packed {
        logic [15:0] reg_addr;
        logic [4:0]  word_count;
        logic [15:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       item_last;
        logic       frame_end;
    } out_item_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic             first;
        logic             last;
        logic [15:0]      reg_addr;
        logic [CNT_W-1:0] word_cnt;
        logic [15:0]      data_word;
    } cmd_t;

    // Queue handshake between front and back
    typedef struct packed {
        logic valid;
    } q_status_t;

    typedef struct packed {
        logic pop;
    } q_ctrl_t;

    // Fold one byte into the CRC, one bit per step
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: src/mwfb_front.sv
// Front end: accepts data words, tracks frame position and queues classified commands.
module mwfb_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mwfb_pkg::in_item_t  in_data,
    output mwfb_pkg::cmd_t      head,
    output mwfb_pkg::q_status_t q_status,
    input  mwfb_pkg::q_ctrl_t   q_ctrl
);

    localparam int Q_DEPTH = 2;

    logic                       in_frame_reg, in_frame_next;
    logic [mwfb_pkg::CNT_W-1:0] words_left_reg, words_left_next;
    logic [mwfb_pkg::CNT_W-1:0] cnt_clamped;
    logic                       accept;
    mwfb_pkg::cmd_t             cmd;

    mwfb_pkg::cmd_t             q_mem [Q_DEPTH];
    logic                       wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                 fill_reg;

    assign in_stall = (fill_reg == 2'(Q_DEPTH));
    assign accept   = in_valid && !in_stall;

    // Clamp the requested count into one .. MAX_WORDS
    always_comb
    begin
        if (32'(in_data.word_count) > mwfb_pkg::MAX_WORDS)
            cnt_clamped = mwfb_pkg::CNT_W'(mwfb_pkg::MAX_WORDS);
        else if (in_data.word_count == 5'd0)
            cnt_clamped = mwfb_pkg::CNT_W'(1);
        else
            cnt_clamped = mwfb_pkg::CNT_W'(in_data.word_count);
    end

    // Classify the request: first of frame, last of frame
    always_comb
    begin
        cmd.first     = !in_frame_reg;
        cmd.reg_addr  = in_data.reg_addr;
        cmd.word_cnt  = cnt_clamped;
        cmd.data_word = in_data.data_word;
        if (!in_frame_reg)
            cmd.last = (cnt_clamped <= mwfb_pkg::CNT_W'(1));
        else
            cmd.last = (words_left_reg <= mwfb_pkg::CNT_W'(1));

        in_frame_next   = in_frame_reg;
        words_left_next = words_left_reg;
        if (accept) begin
            if (cmd.last) begin
                in_frame_next   = 1'b0;
                words_left_next = '0;
            end else begin
                in_frame_next = 1'b1;
                if (!in_frame_reg)
                    words_left_next = cnt_clamped - mwfb_pkg::CNT_W'(1);
                else
                    words_left_next = words_left_reg - mwfb_pkg::CNT_W'(1);
            end
        end
    end

    // Hold frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_frame_reg   <= 1'b0;
            words_left_reg <= '0;
        end else begin
            in_frame_reg   <= in_frame_next;
            words_left_reg <= words_left_next;
        end
    end

    // Write queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
            q_mem[wr_ptr_reg] <= cmd;
    end

    // Advance queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (accept)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_ctrl.pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({accept, q_ctrl.pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    assign head           = q_mem[rd_ptr_reg];
    assign q_status.valid = (fill_reg != 2'd0);

    // Queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= 2'(Q_DEPTH))
        else $error("front queue overfilled");

    // Pop only with an entry present
    assert property (@(posedge clk) disable iff (!rst_n) q_ctrl.pop |-> fill_reg != 2'd0)
        else $error("pop from empty queue");

    // Frame closes on an accepted last word
    assert property (@(posedge clk) disable iff (!rst_n) (accept && cmd.last) |=> !in_frame_reg)
        else $error("frame stayed open after last word");

endmodule

// File: src/mwfb_back.sv
// Back end: serializes queued commands into frame bytes and runs the CRC.
module mwfb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          slave_id,
    input  logic [7:0]          func_code,
    input  mwfb_pkg::cmd_t      head,
    input  mwfb_pkg::q_status_t q_status,
    output mwfb_pkg::q_ctrl_t   q_ctrl,
    output logic                out_valid,
    input  logic                out_stall,
    output mwfb_pkg::out_item_t out_data
);

    localparam int STEP_OFS = 7;

    logic [mwfb_pkg::POS_W-1:0] step_reg;
    logic [mwfb_pkg::POS_W-1:0] pos;
    logic [15:0]                crc_reg;
    logic                       out_valid_reg;
    mwfb_pkg::out_item_t        out_reg;
    logic                       load;
    logic                       byte_last;
    logic                       feed;
    logic [7:0]                 cur_byte;
    logic [15:0]                cnt16;

    // Position in the full frame layout; later words skip the header
    assign pos   = head.first ? step_reg : step_reg + mwfb_pkg::POS_W'(STEP_OFS);
    assign cnt16 = 16'(head.word_cnt);
    assign load  = q_status.valid && (!out_valid_reg || !out_stall);

    assign byte_last = head.last ? (pos == mwfb_pkg::POS_CRC_HI)
                                 : (pos == mwfb_pkg::POS_DATA_LO);

    // Select the byte for this position
    always_comb
    begin
        feed = 1'b1;
        unique case (pos)
            mwfb_pkg::POS_SLAVE:   cur_byte = slave_id;
            mwfb_pkg::POS_FUNC:    cur_byte = func_code;
            mwfb_pkg::POS_ADDR_HI: cur_byte = head.reg_addr[15:8];
            mwfb_pkg::POS_ADDR_LO: cur_byte = head.reg_addr[7:0];
            mwfb_pkg::POS_CNT_HI:  cur_byte = cnt16[15:8];
            mwfb_pkg::POS_CNT_LO:  cur_byte = cnt16[7:0];
            mwfb_pkg::POS_BYTES:   cur_byte = {cnt16[6:0], 1'b0};
            mwfb_pkg::POS_DATA_HI: cur_byte = head.data_word[15:8];
            mwfb_pkg::POS_DATA_LO: cur_byte = head.data_word[7:0];
            mwfb_pkg::POS_CRC_LO:
            begin
                cur_byte = crc_reg[7:0];
                feed     = 1'b0;
            end
            mwfb_pkg::POS_CRC_HI:
            begin
                cur_byte = crc_reg[15:8];
                feed     = 1'b0;
            end
            default:
            begin
                cur_byte = 8'h00;
                feed     = 1'b0;
            end
        endcase
    end

    assign q_ctrl.pop = load && byte_last;

    // Advance step, CRC and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg      <= '0;
            crc_reg       <= mwfb_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                step_reg      <= byte_last ? '0 : step_reg + mwfb_pkg::POS_W'(1);
                if (pos == mwfb_pkg::POS_CRC_HI)
                    crc_reg <= mwfb_pkg::CRC_INIT;
                else if (feed)
                    crc_reg <= mwfb_pkg::crc_feed(crc_reg, cur_byte);
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the output byte
    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg.tx_byte   <= cur_byte;
            out_reg.item_last <= byte_last;
            out_reg.frame_end <= (pos == mwfb_pkg::POS_CRC_HI);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Step stays within the frame layout
    assert property (@(posedge clk) disable iff (!rst_n) step_reg <= mwfb_pkg::POS_CRC_HI)
        else $error("step beyond frame layout");

    // Frame end is always an item's last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.frame_end) |-> out_reg.item_last)
        else $error("frame end without item last");

    // CRC restarts after the closing byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && pos == mwfb_pkg::POS_CRC_HI) |=> crc_reg == mwfb_pkg::CRC_INIT)
        else $error("CRC not restarted after frame");

endmodule

// File: src/modbus_write_frame_builder_top.sv
// Top level: configuration registers and the front/back frame builder pipeline.
// An accepted request is written into the command queue; once the back end is free it registers its first byte.
// Throughput: one output byte per cycle while a command is queued and out_stall is low, set by the single-byte
// output register; a frame's first word yields 9 or 11 bytes, later words 2 bytes (4 on the last).
// A two-entry command queue lets the input keep taking requests while bytes drain.
// Reset (rst_n low, asynchronous): queue empty, no open frame, CRC at 0xFFFF,
// slave id 1, function code 16.
module modbus_write_frame_builder_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  mwfb_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output mwfb_pkg::out_item_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mwfb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data
);

    logic [7:0]          slave_id_reg;
    logic [7:0]          func_code_reg;
    mwfb_pkg::cmd_t      head;
    mwfb_pkg::q_status_t q_status;
    mwfb_pkg::q_ctrl_t   q_ctrl;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slave_id_reg  <= 8'd1;
            func_code_reg <= 8'd16;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mwfb_pkg::CFG_SLAVE_ID:  slave_id_reg  <= cfg_data;
                mwfb_pkg::CFG_FUNC_CODE: func_code_reg <= cfg_data;
                default:                 slave_id_reg  <= slave_id_reg;
            endcase
        end
    end

    mwfb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .head     (head),
        .q_status (q_status),
        .q_ctrl   (q_ctrl)
    );

    mwfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .slave_id  (slave_id_reg),
        .func_code (func_code_reg),
        .head      (head),
        .q_status  (q_status),
        .q_ctrl    (q_ctrl),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: verif/modbus_write_frame_builder_tb.sv
// Testbench for the Modbus write-multiple-registers frame builder: directed and random frames.
`timescale 1ns / 100ps

module testbench;

    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_ITEMS_PER_PHASE = 60;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    mwfb_pkg::in_item_t             in_data = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    mwfb_pkg::out_item_t            out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [mwfb_pkg::CFG_IDX_W-1:0] cfg_index = mwfb_pkg::CFG_SLAVE_ID;
    logic [7:0]                     cfg_data = '0;

    // Idle mix of the current phase, in percent
    int unsigned in_idle_pct = 0;
    int unsigned out_stall_pct = 0;

    // Frame builder shadow: settings, running CRC and frame position
    logic [7:0]          shadow_slave_id = 8'd1;
    logic [7:0]          shadow_func_code = 8'd16;
    logic [15:0]         shadow_crc = mwfb_pkg::CRC_INIT;
    int unsigned         shadow_words_left = 0;
    bit                  shadow_frame_open = 1'b0;
    mwfb_pkg::out_item_t pending_bytes[$];

    // Run statistics
    int unsigned mismatch_count = 0;
    int unsigned requests_taken = 0;
    int unsigned bytes_checked = 0;
    int unsigned frames_closed = 0;
    int unsigned clamped_frames = 0;
    int unsigned settings_written = 0;
    int unsigned quiet_cycles = 0;

    modbus_write_frame_builder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Stall the byte output at the rate of the current phase
    always @(negedge clk)
    begin
        out_stall = ($urandom_range(0, 99) < out_stall_pct);
    end

    // Fold one byte into a CRC-16/Modbus value, LSB first
    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                      input logic [7:0] value);
        logic [15:0] acc;
        acc = crc;
        for (int k = 0; k < 8; k++)
        begin
            if (acc[0] ^ value[k])
                acc = (acc >> 1) ^ mwfb_pkg::CRC_POLY;
            else
                acc = acc >> 1;
        end
        return acc;
    endfunction

    task push_frame_byte(input logic [7:0] value, input bit in_crc,
                         input bit last_of_request, input bit last_of_frame);
        mwfb_pkg::out_item_t b;
        begin
            if (in_crc)
                shadow_crc = crc16_modbus_byte(shadow_crc, value);
            b.tx_byte   = value;
            b.item_last = last_of_request;
            b.frame_end = last_of_frame;
            pending_bytes.push_back(b);
        end
    endtask

    // Predict the bytes that one accepted request produces
    task predict_frame_bytes(input mwfb_pkg::in_item_t req);
        logic [15:0] words;
        logic [15:0] crc_out;
        begin
            if (!shadow_frame_open)
            begin
                // Clamp the count and emit the header
                words = {11'd0, req.word_count};
                if (words > 16'(mwfb_pkg::MAX_WORDS))
                    words = 16'(mwfb_pkg::MAX_WORDS);
                if (words == 16'd0)
                    words = 16'd1;
                shadow_crc = mwfb_pkg::CRC_INIT;
                push_frame_byte(shadow_slave_id, 1'b1, 1'b0, 1'b0);
                push_frame_byte(shadow_func_code, 1'b1, 1'b0, 1'b0);
                push_frame_byte(req.reg_addr[15:8], 1'b1, 1'b0, 1'b0);
                push_frame_byte(req.reg_addr[7:0], 1'b1, 1'b0, 1'b0);
                push_frame_byte(words[15:8], 1'b1, 1'b0, 1'b0);
                push_frame_byte(words[7:0], 1'b1, 1'b0, 1'b0);
                push_frame_byte(8'(words * 2), 1'b1, 1'b0, 1'b0);
                shadow_words_left = 32'(words);
                shadow_frame_open = 1'b1;
            end
            push_frame_byte(req.data_word[15:8], 1'b1, 1'b0, 1'b0);
            if (shadow_words_left <= 1)
            begin
                // Close the frame with the CRC, low byte first
                push_frame_byte(req.data_word[7:0], 1'b1, 1'b0, 1'b0);
                crc_out = shadow_crc;
                push_frame_byte(crc_out[7:0], 1'b0, 1'b0, 1'b0);
                push_frame_byte(crc_out[15:8], 1'b0, 1'b1, 1'b1);
                shadow_crc = mwfb_pkg::CRC_INIT;
                shadow_words_left = 0;
                shadow_frame_open = 1'b0;
            end
            else
            begin
                push_frame_byte(req.data_word[7:0], 1'b1, 1'b1, 1'b0);
                shadow_words_left--;
            end
        end
    endtask

    // Track settings and requests, check each byte against the oldest prediction
    always @(posedge clk)
    begin
        mwfb_pkg::out_item_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mwfb_pkg::CFG_SLAVE_ID)
                    shadow_slave_id = cfg_data;
                else if (cfg_index == mwfb_pkg::CFG_FUNC_CODE)
                    shadow_func_code = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                requests_taken++;
                predict_frame_bytes(in_data);
            end
            if (out_valid && !out_stall)
            begin
                bytes_checked++;
                if (out_data.frame_end === 1'b1)
                    frames_closed++;
                if (pending_bytes.size() == 0)
                begin
                    $error("unexpected byte %02h with nothing pending", out_data.tx_byte);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (out_data.tx_byte !== want.tx_byte)
                    begin
                        $error("tx_byte: expected %02h, got %02h", want.tx_byte,
                               out_data.tx_byte);
                        mismatch_count++;
                    end
                    if (out_data.item_last !== want.item_last)
                    begin
                        $error("item_last: expected %0b, got %0b", want.item_last,
                               out_data.item_last);
                        mismatch_count++;
                    end
                    if (out_data.frame_end !== want.frame_end)
                    begin
                        $error("frame_end: expected %0b, got %0b", want.frame_end,
                               out_data.frame_end);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Abort when no request, byte or register write moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: %0d cycles without progress, %0d bytes pending",
                         quiet_cycles, pending_bytes.size());
                $display("modbus_write_frame_builder_top test failed");
                $finish;
            end
        end
    end

    // Field value biased toward the extremes
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offer one request and hold it until accepted; call and return at a falling edge
    task send_request(input mwfb_pkg::in_item_t req);
        begin
            while ($urandom_range(0, 99) < in_idle_pct)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
            in_valid = 1'b1;
            in_data  = req;
            do
                @(posedge clk);
            while (in_stall);
            @(negedge clk);
        end
    endtask

    // Send a whole frame; later requests carry noise in the header fields
    task automatic send_frame(input logic [15:0] addr, input logic [4:0] count);
        mwfb_pkg::in_item_t req;
        int                 words;
        words = (int'(count) > mwfb_pkg::MAX_WORDS) ? mwfb_pkg::MAX_WORDS :
                ((count == 5'd0) ? 1 : int'(count));
        if (int'(count) > mwfb_pkg::MAX_WORDS)
            clamped_frames++;
        for (int i = 0; i < words; i++)
        begin
            req.data_word = pick_word();
            if (i == 0)
            begin
                req.reg_addr   = addr;
                req.word_count = count;
            end
            else
            begin
                req.reg_addr   = 16'($urandom_range(0, 65535));
                req.word_count = 5'($urandom_range(0, 31));
            end
            send_request(req);
        end
    endtask

    // Let every predicted byte drain, then settle
    task wait_idle();
        begin
            in_valid = 1'b0;
            while (pending_bytes.size() != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
        end
    endtask

    task write_register(input logic [mwfb_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] value);
        begin
            cfg_valid = 1'b1;
            cfg_index = idx;
            cfg_data  = value;
            do
                @(posedge clk);
            while (!cfg_ready);
            @(negedge clk);
            cfg_valid = 1'b0;
            settings_written++;
        end
    endtask

    task set_frame_header(input logic [7:0] slave, input logic [7:0] func);
        begin
            wait_idle();
            write_register(mwfb_pkg::CFG_SLAVE_ID, slave);
            write_register(mwfb_pkg::CFG_FUNC_CODE, func);
        end
    endtask

    // Single-word frames under the reset settings, all-zero and all-one fields
    task test_reset_settings();
        begin
            send_request('{reg_addr: 16'h0000, word_count: 5'd1, data_word: 16'h0000});
            send_request('{reg_addr: 16'hFFFF, word_count: 5'd1, data_word: 16'hFFFF});
        end
    endtask

    // Zero count, clamped count with noisy later requests, alternating bit patterns
    task test_count_edges();
        begin
            send_request('{reg_addr: 16'h1234, word_count: 5'd0, data_word: 16'hBEEF});
            send_frame(16'h5A5A, 5'd31);
            send_request('{reg_addr: 16'hA5A5, word_count: 5'd2, data_word: 16'h5555});
            send_request('{reg_addr: 16'h0000, word_count: 5'd0, data_word: 16'hAAAA});
        end
    endtask

    // Lowest and highest header settings
    task test_setting_extremes();
        begin
            set_frame_header(8'd0, 8'd0);
            send_request('{reg_addr: 16'h00FF, word_count: 5'd1, data_word: 16'hFF00});
            set_frame_header(8'd247, 8'd255);
            send_request('{reg_addr: 16'hFF00, word_count: 5'd1, data_word: 16'h00FF});
        end
    endtask

    // Random frames under a fresh random setting and the given idle mix
    task test_random_frames(input int unsigned sender_pct, input int unsigned receiver_pct);
        int unsigned  start;
        logic [4:0]   count;
        begin
            set_frame_header(8'($urandom_range(0, 247)), 8'($urandom_range(0, 255)));
            in_idle_pct   = sender_pct;
            out_stall_pct = receiver_pct;
            start = requests_taken;
            while (requests_taken - start < RANDOM_ITEMS_PER_PHASE)
            begin
                case ($urandom_range(0, 19))
                    0:       count = 5'd0;
                    1, 2:    count = 5'($urandom_range(17, 31));
                    3, 4:    count = 5'($urandom_range(9, 16));
                    default: count = 5'($urandom_range(1, 8));
                endcase
                send_frame(pick_word(), count);
            end
            in_valid      = 1'b0;
            in_idle_pct   = 0;
            out_stall_pct = 0;
        end
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_settings();
        test_count_edges();
        test_setting_extremes();
        test_random_frames(0, 0);
        test_random_frames(45, 0);
        test_random_frames(0, 45);
        test_random_frames(19, 19);

        // Drain, then watch for stray bytes
        in_valid = 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("covered %0d requests in %0d frames (%0d clamped), %0d bytes checked",
                 requests_taken, frames_closed, clamped_frames, bytes_checked);
        $display("%0d register writes; idle mixes: none, sender, receiver, both",
                 settings_written);
        if (mismatch_count == 0)
            $display("modbus_write_frame_builder_top test passed");
        else
            $display("modbus_write_frame_builder_top test failed");
        $finish;
    end

endmodule

// File: modbus_write_frame_builder_top.f
src/mwfb_pkg.sv
src/mwfb_front.sv
src/mwfb_back.sv
src/modbus_write_frame_builder_top.sv
verif/modbus_write_frame_builder_tb.sv
